FILE: sv/mixed_radix_order_reindex_unit_macros.svh
// assertion macros for the reindex unit
`ifndef MIXED_RADIX_ORDER_REINDEX_UNIT_MACROS_SVH
`define MIXED_RADIX_ORDER_REINDEX_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MRORI_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mrori assertion failed");
`define MRORI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mrori assertion failed");
`else
`define MRORI_ASSERT(lbl, clk, rstn, ante, cons)
`define MRORI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/mrori_pkg.sv
`timescale 1ns / 1ps

package mrori_pkg;

    localparam int MAX_VARS_DEF   = 8;
    localparam int RADIX_BITS_DEF = 4;
    localparam int SLOT_BITS      = 3;
    localparam int NUM_SLOTS      = 8;
    localparam int ORDER_BITS     = SLOT_BITS * NUM_SLOTS;
    localparam int IDX_BITS       = 32;
    localparam int CNT_BITS       = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 4;

    localparam logic [CFG_ADDR_BITS-1:0] REG_VAR_COUNT = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIX_M1  = CFG_ADDR_BITS'(1);

    typedef struct packed {
        logic [ORDER_BITS-1:0] order_packed;
        logic [IDX_BITS-1:0]   enum_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] canonical_index;
        logic                fault;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic fault;
    } ctl_t;

endpackage

FILE: sv/mixed_radix_order_reindex_unit.sv
// path: entry register, the 32-cell digit chain (one cell per index bit), MAX_VARS recombine
// cells and the output register; one transaction per cycle while the output is not stalled,
// all cells advancing together
// reset: synchronous active low; clears valid bits, var_count to 1, radix fields to 0
`timescale 1ns / 1ps
`include "mixed_radix_order_reindex_unit_macros.svh"

module mixed_radix_order_reindex_unit #(
    parameter int MAX_VARS   = mrori_pkg::MAX_VARS_DEF,
    parameter int RADIX_BITS = mrori_pkg::RADIX_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mrori_pkg::in_item_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mrori_pkg::out_item_t                  m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mrori_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
    input  logic [mrori_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int Chain = mrori_pkg::IDX_BITS;
    localparam logic [mrori_pkg::CNT_BITS-1:0] MaxN = mrori_pkg::CNT_BITS'(MAX_VARS);

    // configuration
    logic [mrori_pkg::CNT_BITS-1:0]                         var_count_reg;
    logic [mrori_pkg::CFG_DATA_BITS-1:0]                    radix_m1_reg;
    logic [mrori_pkg::CNT_BITS-1:0]                         n_eff;
    logic [mrori_pkg::NUM_SLOTS-1:0][RADIX_BITS-1:0]        var_rm1;

    // entry stage
    logic [mrori_pkg::NUM_SLOTS-1:0][mrori_pkg::SLOT_BITS-1:0] in_var;
    logic                                                   perm_bad;
    mrori_pkg::ctl_t                                        ent_ctl_reg, ent_ctl_next;
    logic [mrori_pkg::IDX_BITS-1:0]                         ent_h_reg;
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]                    ent_rm1_reg, ent_rm1_next;
    logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]          ent_var_reg;

    // cell chains
    mrori_pkg::ctl_t                                        dc_ctl [Chain+1];
    logic [mrori_pkg::IDX_BITS-1:0]                         dc_h   [Chain+1];
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]                    dc_rm1 [Chain+1];
    logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]          dc_var [Chain+1];
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]                    dc_dig [Chain+1];
    mrori_pkg::ctl_t                                        mc_ctl   [MAX_VARS+1];
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]                    mc_rm1   [MAX_VARS+1];
    logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]          mc_var   [MAX_VARS+1];
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]                    mc_dig   [MAX_VARS+1];
    logic [mrori_pkg::IDX_BITS-1:0]                         mc_canon [MAX_VARS+1];

    // output register
    logic                                                   m_valid_reg;
    mrori_pkg::out_item_t                                   m_data_reg, m_data_next;
    logic                                                   out_load;
    logic                                                   pipe_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_count_reg <= mrori_pkg::CNT_BITS'(1);
            radix_m1_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                mrori_pkg::REG_VAR_COUNT: begin
                    var_count_reg <= cfg_data[mrori_pkg::CNT_BITS-1:0];
                end
                mrori_pkg::REG_RADIX_M1: begin
                    radix_m1_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (var_count_reg == '0) begin
            n_eff = mrori_pkg::CNT_BITS'(1);
        end else if (var_count_reg > MaxN) begin
            n_eff = MaxN;
        end else begin
            n_eff = var_count_reg;
        end
    end

    for (genvar i = 0; i < mrori_pkg::NUM_SLOTS; i++) begin : g_rm1
        if (i < MAX_VARS && i * RADIX_BITS < mrori_pkg::CFG_DATA_BITS) begin : g_field
            assign var_rm1[i] = RADIX_BITS'(radix_m1_reg >> (i * RADIX_BITS));
        end else begin : g_none
            assign var_rm1[i] = '0;
        end
    end

    // order check and per-slot radix lookup
    assign in_var = s_data.order_packed;

    always_comb begin
        perm_bad     = 1'b0;
        ent_rm1_next = '0;
        for (int k = 0; k < MAX_VARS; k++) begin
            if (mrori_pkg::CNT_BITS'(k) < n_eff) begin
                if (mrori_pkg::CNT_BITS'(in_var[k]) >= n_eff) begin
                    perm_bad = 1'b1;
                end
                for (int j = 0; j < k; j++) begin
                    if (in_var[j] == in_var[k]) begin
                        perm_bad = 1'b1;
                    end
                end
                ent_rm1_next[k] = var_rm1[in_var[k]];
            end
        end
        ent_ctl_next.valid = s_valid;
        ent_ctl_next.fault = perm_bad;
    end

    assign out_load = !m_valid_reg || m_ready;
    assign pipe_en  = !mc_ctl[MAX_VARS].valid || out_load;
    assign s_ready  = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_ctl_reg <= '0;
        end else if (pipe_en) begin
            ent_ctl_reg <= ent_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ent_h_reg   <= s_data.enum_index;
            ent_rm1_reg <= ent_rm1_next;
            ent_var_reg <= in_var[MAX_VARS-1:0];
        end
    end

    assign dc_ctl[0] = ent_ctl_reg;
    assign dc_h[0]   = ent_h_reg;
    assign dc_rm1[0] = ent_rm1_reg;
    assign dc_var[0] = ent_var_reg;
    assign dc_dig[0] = '0;

    for (genvar b = 0; b < Chain; b++) begin : g_digit
        mrori_digit_cell #(
            .MAX_VARS   (MAX_VARS),
            .RADIX_BITS (RADIX_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .ctl_in  (dc_ctl[b]),
            .h_in    (dc_h[b]),
            .rm1_in  (dc_rm1[b]),
            .var_in  (dc_var[b]),
            .dig_in  (dc_dig[b]),
            .ctl_out (dc_ctl[b+1]),
            .h_out   (dc_h[b+1]),
            .rm1_out (dc_rm1[b+1]),
            .var_out (dc_var[b+1]),
            .dig_out (dc_dig[b+1])
        );
    end

    assign mc_ctl[0]   = dc_ctl[Chain];
    assign mc_rm1[0]   = dc_rm1[Chain];
    assign mc_var[0]   = dc_var[Chain];
    assign mc_dig[0]   = dc_dig[Chain];
    assign mc_canon[0] = '0;

    for (genvar v = 0; v < MAX_VARS; v++) begin : g_mac
        mrori_mac_cell #(
            .MAX_VARS   (MAX_VARS),
            .RADIX_BITS (RADIX_BITS),
            .VAR_IDX    (v)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .n_vars    (n_eff),
            .ctl_in    (mc_ctl[v]),
            .rm1_in    (mc_rm1[v]),
            .var_in    (mc_var[v]),
            .dig_in    (mc_dig[v]),
            .canon_in  (mc_canon[v]),
            .ctl_out   (mc_ctl[v+1]),
            .rm1_out   (mc_rm1[v+1]),
            .var_out   (mc_var[v+1]),
            .dig_out   (mc_dig[v+1]),
            .canon_out (mc_canon[v+1])
        );
    end

    always_comb begin
        m_data_next.fault           = mc_ctl[MAX_VARS].fault;
        m_data_next.canonical_index = mc_ctl[MAX_VARS].fault ? '0 : mc_canon[MAX_VARS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= mc_ctl[MAX_VARS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MRORI_ASSERT(a_stall_cause, aclk, aresetn, !s_ready, mc_ctl[MAX_VARS].valid && m_valid_reg && !m_ready)
    `MRORI_ASSERT_NXT(a_entry_hold, aclk, aresetn, !pipe_en, $stable(ent_ctl_reg))
    `MRORI_ASSERT(a_fault_zero, aclk, aresetn, m_valid_reg && m_data_reg.fault, m_data_reg.canonical_index == '0)

endmodule

FILE: sv/mrori_digit_cell.sv
`timescale 1ns / 1ps
`include "mixed_radix_order_reindex_unit_macros.svh"

module mrori_digit_cell #(
    parameter int MAX_VARS   = mrori_pkg::MAX_VARS_DEF,
    parameter int RADIX_BITS = mrori_pkg::RADIX_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  mrori_pkg::ctl_t                                 ctl_in,
    input  logic [mrori_pkg::IDX_BITS-1:0]                  h_in,
    input  logic [MAX_VARS-1:0][RADIX_BITS-1:0]             rm1_in,
    input  logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]   var_in,
    input  logic [MAX_VARS-1:0][RADIX_BITS-1:0]             dig_in,
    output mrori_pkg::ctl_t                                 ctl_out,
    output logic [mrori_pkg::IDX_BITS-1:0]                  h_out,
    output logic [MAX_VARS-1:0][RADIX_BITS-1:0]             rm1_out,
    output logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]   var_out,
    output logic [MAX_VARS-1:0][RADIX_BITS-1:0]             dig_out
);

    mrori_pkg::ctl_t                                ctl_reg, ctl_next;
    logic [mrori_pkg::IDX_BITS-1:0]                 h_reg, h_next;
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]            rm1_reg;
    logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]  var_reg;
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]            dig_reg, dig_next;
    logic                                           carry;
    logic [RADIX_BITS:0]                            dbl;
    logic [RADIX_BITS:0]                            radix;

    // double the mixed-radix value and add the next index bit
    always_comb begin
        carry    = h_in[mrori_pkg::IDX_BITS-1];
        dig_next = dig_in;
        dbl      = '0;
        radix    = '0;
        for (int s = MAX_VARS - 1; s >= 0; s--) begin
            dbl   = {dig_in[s], carry};
            radix = {1'b0, rm1_in[s]} + 1'b1;
            if (dbl >= radix) begin
                dig_next[s] = RADIX_BITS'(dbl - radix);
                carry       = 1'b1;
            end else begin
                dig_next[s] = RADIX_BITS'(dbl);
                carry       = 1'b0;
            end
        end
        ctl_next.valid = ctl_in.valid;
        ctl_next.fault = ctl_in.fault | carry;
        h_next         = {h_in[mrori_pkg::IDX_BITS-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg   <= h_next;
            rm1_reg <= rm1_in;
            var_reg <= var_in;
            dig_reg <= dig_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign h_out   = h_reg;
    assign rm1_out = rm1_reg;
    assign var_out = var_reg;
    assign dig_out = dig_reg;

    `MRORI_ASSERT_NXT(a_fault_sticky, aclk, aresetn, en && ctl_in.valid && ctl_in.fault, ctl_reg.fault)

    for (genvar s = 0; s < MAX_VARS; s++) begin : g_chk
        `MRORI_ASSERT(a_dig_below_radix, aclk, aresetn, ctl_reg.valid, dig_reg[s] <= rm1_reg[s])
    end

endmodule

FILE: sv/mrori_mac_cell.sv
`timescale 1ns / 1ps

module mrori_mac_cell #(
    parameter int MAX_VARS   = mrori_pkg::MAX_VARS_DEF,
    parameter int RADIX_BITS = mrori_pkg::RADIX_BITS_DEF,
    parameter int VAR_IDX    = 0
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  logic [mrori_pkg::CNT_BITS-1:0]                  n_vars,
    input  mrori_pkg::ctl_t                                 ctl_in,
    input  logic [MAX_VARS-1:0][RADIX_BITS-1:0]             rm1_in,
    input  logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]   var_in,
    input  logic [MAX_VARS-1:0][RADIX_BITS-1:0]             dig_in,
    input  logic [mrori_pkg::IDX_BITS-1:0]                  canon_in,
    output mrori_pkg::ctl_t                                 ctl_out,
    output logic [MAX_VARS-1:0][RADIX_BITS-1:0]             rm1_out,
    output logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]   var_out,
    output logic [MAX_VARS-1:0][RADIX_BITS-1:0]             dig_out,
    output logic [mrori_pkg::IDX_BITS-1:0]                  canon_out
);

    localparam int ProdBits = mrori_pkg::IDX_BITS + RADIX_BITS + 1;

    mrori_pkg::ctl_t                                ctl_reg;
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]            rm1_reg;
    logic [MAX_VARS-1:0][mrori_pkg::SLOT_BITS-1:0]  var_reg;
    logic [MAX_VARS-1:0][RADIX_BITS-1:0]            dig_reg;
    logic [mrori_pkg::IDX_BITS-1:0]                 canon_reg, canon_next;
    logic                                           used;
    logic [RADIX_BITS-1:0]                          sel_dig;
    logic [RADIX_BITS-1:0]                          sel_rm1;
    logic [RADIX_BITS:0]                            radix;
    logic [ProdBits-1:0]                            prod;

    // pick the slot that holds this variable, then one horner step
    always_comb begin
        used    = mrori_pkg::CNT_BITS'(VAR_IDX) < n_vars;
        sel_dig = '0;
        sel_rm1 = '0;
        for (int s = 0; s < MAX_VARS; s++) begin
            if (mrori_pkg::CNT_BITS'(s) < n_vars &&
                var_in[s] == mrori_pkg::SLOT_BITS'(VAR_IDX)) begin
                sel_dig = dig_in[s];
                sel_rm1 = rm1_in[s];
            end
        end
        radix = {1'b0, sel_rm1} + 1'b1;
        prod  = {{(RADIX_BITS + 1){1'b0}}, canon_in} *
                {{mrori_pkg::IDX_BITS{1'b0}}, radix} +
                {{(ProdBits - RADIX_BITS){1'b0}}, sel_dig};
        canon_next = used ? prod[mrori_pkg::IDX_BITS-1:0] : canon_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rm1_reg   <= rm1_in;
            var_reg   <= var_in;
            dig_reg   <= dig_in;
            canon_reg <= canon_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign rm1_out   = rm1_reg;
    assign var_out   = var_reg;
    assign dig_out   = dig_reg;
    assign canon_out = canon_reg;

endmodule
